[rtl/nrsss_pkg.sv]
// shared constants, register codes and sequence tables of the nr sss sequence mapper
package nrsss_pkg;

    localparam int SEQ_LEN            = 127;
    localparam int MAX_SYMBOL_SIZE    = 4096;
    localparam int SYMBOLS_PER_BUFFER = 14;

    localparam int SSS_MAG     = 23170;
    localparam int SUB_BASE    = 56;
    localparam int SYM_BASE    = 2;
    localparam int SHIFT_GROUP = 112;
    localparam int M0_STEP     = 15;
    localparam int N2_STEP     = 5;
    localparam int N2_DIV      = 3;
    localparam int DIV3_MUL    = 683;
    localparam int DIV3_SHIFT  = 11;
    localparam int SCALE_SHIFT = 15;

    localparam int IDX_W      = 7;
    localparam int ID_W       = 10;
    localparam int N1_W       = 9;
    localparam int DIV3_W     = 20;
    localparam int AMP_W      = 16;
    localparam int SYM_W      = 4;
    localparam int SUB_W      = 12;
    localparam int SIZE_W     = 13;
    localparam int T_W        = 14;
    localparam int WIDE_W     = 27;
    localparam int SYMSIZE_W  = 16;
    localparam int OFF_W      = 17;
    localparam int PROD_W     = 32;
    localparam int REG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_CELL_IDENTITY          = 3'd0,
        REG_AMPLITUDE              = 3'd1,
        REG_BLOCK_START_SYMBOL     = 3'd2,
        REG_CARRIER_OFFSET         = 3'd3,
        REG_BLOCK_START_SUBCARRIER = 3'd4,
        REG_SYMBOL_SIZE            = 3'd5
    } cfg_reg_t;

    // x0: x^7 + x^4 + 1, seeded 1,0,0,0,0,0,0
    function automatic logic [SEQ_LEN-1:0] build_x0();
        logic [SEQ_LEN-1:0] x;
        x = '0;
        x[0] = 1'b1;
        for (int i = 0; i + 7 < SEQ_LEN; i++)
        begin
            x[i+7] = x[i+4] ^ x[i];
        end
        return x;
    endfunction

    // x1: x^7 + x + 1, same seed
    function automatic logic [SEQ_LEN-1:0] build_x1();
        logic [SEQ_LEN-1:0] x;
        x = '0;
        x[0] = 1'b1;
        for (int i = 0; i + 7 < SEQ_LEN; i++)
        begin
            x[i+7] = x[i+1] ^ x[i];
        end
        return x;
    endfunction

    localparam logic [SEQ_LEN-1:0] SEQ_X0 = build_x0();
    localparam logic [SEQ_LEN-1:0] SEQ_X1 = build_x1();

endpackage

[rtl/nrsss_if.sv]
// stream and configuration interfaces of the nr sss sequence mapper
interface nrsss_element_if import nrsss_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] element_index;

    modport source (output valid, output element_index, input ready);
    modport sink (input valid, input element_index, output ready);
endinterface

interface nrsss_sample_if import nrsss_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [AMP_W-1:0] sequence_value;
    logic signed [AMP_W-1:0] scaled_sample;
    logic [SYM_W-1:0]        symbol_number;
    logic [SUB_W-1:0]        subcarrier;
    logic [OFF_W-1:0]        buffer_offset;

    modport source (
        output valid, output sequence_value, output scaled_sample,
        output symbol_number, output subcarrier, output buffer_offset,
        input ready
    );
    modport sink (
        input valid, input sequence_value, input scaled_sample,
        input symbol_number, input subcarrier, input buffer_offset,
        output ready
    );
endinterface

interface nrsss_cfg_if import nrsss_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [REG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

[rtl/nrsss_rem_steps.sv]
// a slice of restoring remainder steps, one compare and subtract per shift position
module nrsss_rem_steps import nrsss_pkg::*; #(
    parameter int HI_STEP = 13,
    parameter int LO_STEP = 10
) (
    input  logic [T_W-1:0]    rem_in,
    input  logic [SIZE_W-1:0] size,
    output logic [T_W-1:0]    rem_out
);

    always_comb
    begin
        logic [WIDE_W-1:0] r;
        logic [WIDE_W-1:0] dv;
        r = WIDE_W'(rem_in);
        dv = '0;
        for (int j = HI_STEP; j >= LO_STEP; j--)
        begin
            dv = WIDE_W'(size) << j;
            if (r >= dv)
            begin
                r = r - dv;
            end
        end
        rem_out = r[T_W-1:0];
    end

endmodule

[rtl/nr_sss_sequence_mapper.sv]
// nr sss sequence mapper: five-stage pipeline, one element beat in per cycle
// while sample.ready does not stall it; a result passes stage registers one to five
// in order before it is valid; the subcarrier remainder is spread as
// restoring steps over stages two to four, the gain multiply sits in stage four
// reset: pipeline valid bits clear, registers return to id 0, gain 0,
// start symbol 0, offsets 0, symbol size 4096
module nr_sss_sequence_mapper import nrsss_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    nrsss_cfg_if.sink     cfg,
    nrsss_element_if.sink element,
    nrsss_sample_if.source sample
);

    // configuration registers
    logic [ID_W-1:0]   cell_identity_reg;
    logic [AMP_W-1:0]  amplitude_reg;
    logic [SYM_W-1:0]  block_start_symbol_reg;
    logic [SUB_W-1:0]  carrier_offset_reg;
    logic [SUB_W-1:0]  block_start_subcarrier_reg;
    logic [SIZE_W-1:0] symbol_size_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_identity_reg          <= '0;
            amplitude_reg              <= '0;
            block_start_symbol_reg     <= '0;
            carrier_offset_reg         <= '0;
            block_start_subcarrier_reg <= '0;
            symbol_size_reg            <= SIZE_W'(MAX_SYMBOL_SIZE);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.reg_index)
                REG_CELL_IDENTITY:          cell_identity_reg <= cfg.wdata[ID_W-1:0];
                REG_AMPLITUDE:              amplitude_reg <= cfg.wdata[AMP_W-1:0];
                REG_BLOCK_START_SYMBOL:     block_start_symbol_reg <= cfg.wdata[SYM_W-1:0];
                REG_CARRIER_OFFSET:         carrier_offset_reg <= cfg.wdata[SUB_W-1:0];
                REG_BLOCK_START_SUBCARRIER:
                    block_start_subcarrier_reg <= cfg.wdata[SUB_W-1:0];
                REG_SYMBOL_SIZE:            symbol_size_reg <= cfg.wdata[SIZE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // pipeline valid bits and stage enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    assign en5 = !v5_reg || sample.ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign element.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= element.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    // stage 1: element index, id / 3, wrap sum, saturated size and symbol
    logic [IDX_W-1:0]  n_next;
    logic [DIV3_W-1:0] div3_prod;
    logic [N1_W-1:0]   n1_next;
    logic [SIZE_W-1:0] size_next;
    logic [SYM_W-1:0]  sym_sat;
    logic [SYM_W-1:0]  sym_next;
    logic [T_W-1:0]    t_next;

    logic [IDX_W-1:0]  n1s_reg;
    logic [ID_W-1:0]   id1_reg;
    logic [N1_W-1:0]   n1_reg;
    logic [T_W-1:0]    t1_reg;
    logic [SIZE_W-1:0] size1_reg;
    logic [SYM_W-1:0]  sym1_reg;
    logic [AMP_W-1:0]  amp1_reg;

    always_comb
    begin
        n_next = (element.element_index == IDX_W'(SEQ_LEN)) ? '0 : element.element_index;
        div3_prod = DIV3_W'(cell_identity_reg) * DIV3_W'(DIV3_MUL);
        n1_next = div3_prod[DIV3_SHIFT +: N1_W];
        if (symbol_size_reg == '0 || symbol_size_reg > SIZE_W'(MAX_SYMBOL_SIZE))
        begin
            size_next = SIZE_W'(MAX_SYMBOL_SIZE);
        end
        else
        begin
            size_next = symbol_size_reg;
        end
        sym_sat = (block_start_symbol_reg > SYM_W'(SYMBOLS_PER_BUFFER - 3))
                ? SYM_W'(SYMBOLS_PER_BUFFER - 3) : block_start_symbol_reg;
        sym_next = sym_sat + SYM_W'(SYM_BASE);
        t_next = T_W'(carrier_offset_reg) + T_W'(block_start_subcarrier_reg)
               + T_W'(SUB_BASE) + T_W'(n_next);
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            n1s_reg   <= n_next;
            id1_reg   <= cell_identity_reg;
            n1_reg    <= n1_next;
            t1_reg    <= t_next;
            size1_reg <= size_next;
            sym1_reg  <= sym_next;
            amp1_reg  <= amplitude_reg;
        end
    end

    // stage 2: cyclic shifts to table indexes, first remainder steps, symbol base
    logic [1:0]         n2_val;
    logic [1:0]         grp_val;
    logic [IDX_W-1:0]   m1_val;
    logic [5:0]         m0_val;
    logic [IDX_W:0]     sa_val;
    logic [IDX_W:0]     sb_val;
    logic [IDX_W-1:0]   idx_a_next;
    logic [IDX_W-1:0]   idx_b_next;
    logic [T_W-1:0]     r2_next;
    logic [SYMSIZE_W-1:0] symsize_next;

    logic [IDX_W-1:0]     idx_a2_reg;
    logic [IDX_W-1:0]     idx_b2_reg;
    logic [T_W-1:0]       r2_reg;
    logic [SIZE_W-1:0]    size2_reg;
    logic [SYMSIZE_W-1:0] symsize2_reg;
    logic [SYM_W-1:0]     sym2_reg;
    logic [AMP_W-1:0]     amp2_reg;

    always_comb
    begin
        n2_val = 2'(id1_reg - ID_W'(N2_DIV) * ID_W'(n1_reg));
        priority if (n1_reg >= N1_W'(3 * SHIFT_GROUP))
        begin
            grp_val = 2'd3;
        end
        else if (n1_reg >= N1_W'(2 * SHIFT_GROUP))
        begin
            grp_val = 2'd2;
        end
        else if (n1_reg >= N1_W'(SHIFT_GROUP))
        begin
            grp_val = 2'd1;
        end
        else
        begin
            grp_val = 2'd0;
        end
        m1_val = IDX_W'(n1_reg - N1_W'(SHIFT_GROUP) * N1_W'(grp_val));
        m0_val = 6'(6'(M0_STEP) * 6'(grp_val) + 6'(N2_STEP) * 6'(n2_val));
        sa_val = (IDX_W+1)'(n1s_reg) + (IDX_W+1)'(m0_val);
        sb_val = (IDX_W+1)'(n1s_reg) + (IDX_W+1)'(m1_val);
        idx_a_next = (sa_val >= (IDX_W+1)'(SEQ_LEN))
                   ? IDX_W'(sa_val - (IDX_W+1)'(SEQ_LEN)) : sa_val[IDX_W-1:0];
        idx_b_next = (sb_val >= (IDX_W+1)'(SEQ_LEN))
                   ? IDX_W'(sb_val - (IDX_W+1)'(SEQ_LEN)) : sb_val[IDX_W-1:0];
        symsize_next = SYMSIZE_W'(sym1_reg) * SYMSIZE_W'(size1_reg);
    end

    nrsss_rem_steps #(
        .HI_STEP (13),
        .LO_STEP (10)
    ) u_rem_a (
        .rem_in  (t1_reg),
        .size    (size1_reg),
        .rem_out (r2_next)
    );

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            idx_a2_reg   <= idx_a_next;
            idx_b2_reg   <= idx_b_next;
            r2_reg       <= r2_next;
            size2_reg    <= size1_reg;
            symsize2_reg <= symsize_next;
            sym2_reg     <= sym1_reg;
            amp2_reg     <= amp1_reg;
        end
    end

    // stage 3: table lookups give the bipolar element, middle remainder steps
    logic                    chip_bit;
    logic signed [AMP_W-1:0] d_next;
    logic [T_W-1:0]          r3_next;

    logic signed [AMP_W-1:0] d3_reg;
    logic [T_W-1:0]          r3_reg;
    logic [SIZE_W-1:0]       size3_reg;
    logic [SYMSIZE_W-1:0]    symsize3_reg;
    logic [SYM_W-1:0]        sym3_reg;
    logic signed [AMP_W-1:0] amp3_reg;

    always_comb
    begin
        chip_bit = SEQ_X0[idx_a2_reg] ^ SEQ_X1[idx_b2_reg];
        d_next = chip_bit ? -AMP_W'(SSS_MAG) : AMP_W'(SSS_MAG);
    end

    nrsss_rem_steps #(
        .HI_STEP (9),
        .LO_STEP (5)
    ) u_rem_b (
        .rem_in  (r2_reg),
        .size    (size2_reg),
        .rem_out (r3_next)
    );

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            d3_reg       <= d_next;
            r3_reg       <= r3_next;
            size3_reg    <= size2_reg;
            symsize3_reg <= symsize2_reg;
            sym3_reg     <= sym2_reg;
            amp3_reg     <= amp2_reg;
        end
    end

    // stage 4: gain multiply, last remainder steps
    logic signed [PROD_W-1:0] prod_next;
    logic [T_W-1:0]           r4_next;

    logic signed [PROD_W-1:0] prod4_reg;
    logic [SUB_W-1:0]         k4_reg;
    logic signed [AMP_W-1:0]  d4_reg;
    logic [SYMSIZE_W-1:0]     symsize4_reg;
    logic [SYM_W-1:0]         sym4_reg;

    assign prod_next = PROD_W'(amp3_reg) * PROD_W'(d3_reg);

    nrsss_rem_steps #(
        .HI_STEP (4),
        .LO_STEP (0)
    ) u_rem_c (
        .rem_in  (r3_reg),
        .size    (size3_reg),
        .rem_out (r4_next)
    );

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            prod4_reg    <= prod_next;
            k4_reg       <= r4_next[SUB_W-1:0];
            d4_reg       <= d3_reg;
            symsize4_reg <= symsize3_reg;
            sym4_reg     <= sym3_reg;
        end
    end

    // stage 5: output register
    logic [OFF_W-1:0] word_sum;

    logic signed [AMP_W-1:0] seq5_reg;
    logic signed [AMP_W-1:0] scaled5_reg;
    logic [SYM_W-1:0]        sym5_reg;
    logic [SUB_W-1:0]        sub5_reg;
    logic [OFF_W-1:0]        off5_reg;

    // complex pairs: real word sits at twice the sample index
    assign word_sum = OFF_W'(symsize4_reg) + OFF_W'(k4_reg);

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            seq5_reg    <= d4_reg;
            scaled5_reg <= prod4_reg[SCALE_SHIFT +: AMP_W];
            sym5_reg    <= sym4_reg;
            sub5_reg    <= k4_reg;
            off5_reg    <= {word_sum[OFF_W-2:0], 1'b0};
        end
    end

    assign sample.valid          = v5_reg;
    assign sample.sequence_value = seq5_reg;
    assign sample.scaled_sample  = scaled5_reg;
    assign sample.symbol_number  = sym5_reg;
    assign sample.subcarrier     = sub5_reg;
    assign sample.buffer_offset  = off5_reg;

`ifndef ASSERT_OFF
    a_seq_bipolar: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid |-> (sample.sequence_value == AMP_W'(SSS_MAG)
                       || sample.sequence_value == -AMP_W'(SSS_MAG)))
        else $error("sequence value is not bipolar");

    a_partial_rem: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> (WIDE_W'(r3_reg) < (WIDE_W'(size3_reg) << 5)))
        else $error("partial remainder out of range after middle steps");

    a_symbol_range: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid |-> (sample.symbol_number >= SYM_W'(SYM_BASE)
                       && sample.symbol_number <= SYM_W'(SYMBOLS_PER_BUFFER - 1)))
        else $error("symbol number outside buffer");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg |-> element.ready)
        else $error("empty first stage refuses an element beat");
`endif

endmodule
